// File: src/pau_pkg.sv
// Package: shared types and codes for the Pareto archive block.
`default_nettype none
package pau_pkg;

  typedef enum logic [1:0] {
    REQ_OFFER = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PACK,
    ST_APPEND,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  read_index;
    logic [15:0] candidate_tag;
    logic [15:0] candidate_violation;
    logic [23:0] candidate_length;
    logic [23:0] candidate_cost;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        full_drop;
    logic [4:0]  entry_count;
    logic [23:0] min_length;
    logic [23:0] max_length_seen;
    logic [23:0] lowest_cost;
    logic [23:0] max_cost;
    logic        entry_valid;
    logic [15:0] entry_tag;
    logic [15:0] entry_violation;
    logic [23:0] entry_length;
    logic [23:0] entry_cost;
  } out_item_t;

  localparam int EntryW = 80;
  localparam logic [23:0] Ones24 = 24'hFFFFFF;

endpackage
`default_nettype wire

// File: src/pau_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module pau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/pareto_archive_update.sv
// Top level: Pareto archive update engine with one shared compare unit.
//
// Usage
//   Input channel in_valid/in_ready/in_item carries one request item:
//   offer a candidate, read an entry, or clear the archive. Result channel
//   out_valid/out_ready/out_item returns exactly one item per request.
//   The archive sits in one RAM with a registered read; a small sequencer
//   feeds it through one dominance compare and one min/max update.
//   Offer:
//     scan  : read top down, one entry a cycle, stop at the first entry
//             that rejects the candidate;
//     pack  : read bottom up, close over removed entries in place, keep
//             order and rebuild the extremes;
//     append: write the candidate if there is room.
//   in_ready is high only while idle; the next item is taken in the cycle
//   after the result is taken at the earliest. A stalled receiver holds
//   the result in the output register and the input waits meanwhile.
//   Reset (rst_n low, synchronous) empties the archive and sets the marks
//   to their empty values; RAM contents are left as they are.
`default_nettype none
module pareto_archive_update #(
  parameter int ARCHIVE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pau_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pau_pkg::out_item_t       out_item
);
  localparam int AW = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
  localparam int CW = $clog2(ARCHIVE_DEPTH + 1);

  pau_pkg::state_t state_r, state_nxt;
  pau_pkg::in_item_t req_r, req_nxt;
  pau_pkg::out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [CW-1:0] count_r, count_nxt;
  // next read address
  logic [CW-1:0] idx_r, idx_nxt;
  // index of the entry now on rdata
  logic [CW-1:0] didx_r, didx_nxt;
  // compaction write pointer
  logic [CW-1:0] wptr_r, wptr_nxt;
  // lowest index that may be removed (one above the rejecting entry)
  logic [CW-1:0] base_r, base_nxt;
  logic          rej_r, rej_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [23:0]   lmin_r, lmin_nxt, lmax_r, lmax_nxt;
  logic [23:0]   cmin_r, cmin_nxt, cmax_r, cmax_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [pau_pkg::EntryW-1:0] wdata, rdata;

  pau_ram #(.WIDTH(pau_pkg::EntryW), .DEPTH(ARCHIVE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic [15:0] e_tag, e_vio;
  logic [23:0] e_len, e_cost;
  assign {e_tag, e_vio, e_len, e_cost} = rdata;

  // dominance compare of the entry just read against the candidate
  logic rej, drop;
  always_comb begin
    rej  = 1'b0;
    drop = 1'b0;
    if (e_vio < req_r.candidate_violation) begin
      rej = 1'b1;
    end else if (e_vio > req_r.candidate_violation) begin
      drop = 1'b1;
    end else if (e_len <= req_r.candidate_length && e_cost <= req_r.candidate_cost) begin
      rej = 1'b1;
    end else if (e_len >= req_r.candidate_length && e_cost >= req_r.candidate_cost) begin
      drop = 1'b1;
    end
  end

  // entries at and below the rejecting one stay; above it drop what is dominated
  logic keep;
  assign keep = (didx_r < base_r) || !drop;

  assign in_ready  = (state_r == pau_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pau_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      didx_r      <= '0;
      wptr_r      <= '0;
      base_r      <= '0;
      rej_r       <= 1'b0;
      rd_pend_r   <= 1'b0;
      lmin_r      <= pau_pkg::Ones24;
      lmax_r      <= '0;
      cmin_r      <= pau_pkg::Ones24;
      cmax_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      didx_r      <= didx_nxt;
      wptr_r      <= wptr_nxt;
      base_r      <= base_nxt;
      rej_r       <= rej_nxt;
      rd_pend_r   <= rd_pend_nxt;
      lmin_r      <= lmin_nxt;
      lmax_r      <= lmax_nxt;
      cmin_r      <= cmin_nxt;
      cmax_r      <= cmax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  logic [CW-1:0] k;
  assign k = idx_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    didx_nxt      = didx_r;
    wptr_nxt      = wptr_r;
    base_nxt      = base_r;
    rej_nxt       = rej_r;
    rd_pend_nxt   = 1'b0;
    lmin_nxt      = lmin_r;
    lmax_nxt      = lmax_r;
    cmin_nxt      = cmin_r;
    cmax_nxt      = cmax_r;
    we            = 1'b0;
    waddr         = wptr_r[AW-1:0];
    wdata         = rdata;
    raddr         = idx_r[AW-1:0];

    unique case (state_r)
      pau_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_item;
          res_nxt  = '0;
          idx_nxt  = count_r;
          wptr_nxt = '0;
          base_nxt = '0;
          rej_nxt  = 1'b0;
          unique case (pau_pkg::req_t'(in_item.req_type))
            pau_pkg::REQ_OFFER: state_nxt = pau_pkg::ST_SCAN;
            pau_pkg::REQ_READ:  state_nxt = pau_pkg::ST_READ;
            pau_pkg::REQ_CLEAR: begin
              count_nxt = '0;
              lmin_nxt  = pau_pkg::Ones24;
              lmax_nxt  = '0;
              cmin_nxt  = pau_pkg::Ones24;
              cmax_nxt  = '0;
              state_nxt = pau_pkg::ST_DONE;
            end
            default: state_nxt = pau_pkg::ST_DONE;
          endcase
        end
      end

      // top-down search for the first entry that rejects the candidate;
      // issue one read a cycle and compare the entry read last cycle
      pau_pkg::ST_SCAN: begin
        if (rd_pend_r && rej) begin
          rej_nxt   = 1'b1;
          base_nxt  = didx_r + CW'(1);
          state_nxt = pau_pkg::ST_PACK;
          idx_nxt   = '0;
          wptr_nxt  = '0;
          lmin_nxt  = pau_pkg::Ones24;
          lmax_nxt  = '0;
          cmin_nxt  = pau_pkg::Ones24;
          cmax_nxt  = '0;
        end else if (idx_r != '0) begin
          raddr       = k[AW-1:0];
          idx_nxt     = k;
          didx_nxt    = k;
          rd_pend_nxt = 1'b1;
        end else begin
          state_nxt = pau_pkg::ST_PACK;
          idx_nxt   = '0;
          wptr_nxt  = '0;
          lmin_nxt  = pau_pkg::Ones24;
          lmax_nxt  = '0;
          cmin_nxt  = pau_pkg::Ones24;
          cmax_nxt  = '0;
        end
      end

      // bottom-up pass: write kept entries down to the write pointer and
      // fold them into the extremes, one entry a cycle
      pau_pkg::ST_PACK: begin
        if (rd_pend_r && keep) begin
          wptr_nxt = wptr_r + CW'(1);
          if (wptr_r != didx_r) begin
            we    = 1'b1;
            waddr = wptr_r[AW-1:0];
            wdata = rdata;
          end
          if (e_len < lmin_r) lmin_nxt = e_len;
          if (e_len > lmax_r) lmax_nxt = e_len;
          if (e_cost < cmin_r) cmin_nxt = e_cost;
          if (e_cost > cmax_r) cmax_nxt = e_cost;
        end
        if (idx_r < count_r) begin
          raddr       = idx_r[AW-1:0];
          didx_nxt    = idx_r;
          idx_nxt     = idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          count_nxt = wptr_nxt;
          state_nxt = rej_r ? pau_pkg::ST_DONE : pau_pkg::ST_APPEND;
        end
      end

      // append the surviving candidate, or drop it when full
      pau_pkg::ST_APPEND: begin
        if (count_r < CW'(ARCHIVE_DEPTH)) begin
          we    = 1'b1;
          waddr = count_r[AW-1:0];
          wdata = {req_r.candidate_tag, req_r.candidate_violation,
                   req_r.candidate_length, req_r.candidate_cost};
          count_nxt = count_r + CW'(1);
          res_nxt.accepted = 1'b1;
          if (req_r.candidate_length < lmin_r) lmin_nxt = req_r.candidate_length;
          if (req_r.candidate_length > lmax_r) lmax_nxt = req_r.candidate_length;
          if (req_r.candidate_cost < cmin_r) cmin_nxt = req_r.candidate_cost;
          if (req_r.candidate_cost > cmax_r) cmax_nxt = req_r.candidate_cost;
        end else begin
          res_nxt.full_drop = 1'b1;
        end
        state_nxt = pau_pkg::ST_DONE;
      end

      pau_pkg::ST_READ: begin
        raddr = AW'(req_r.read_index);
        if (rd_pend_r) begin
          if (32'(req_r.read_index) < 32'(count_r)) begin
            res_nxt.entry_valid     = 1'b1;
            res_nxt.entry_tag       = e_tag;
            res_nxt.entry_violation = e_vio;
            res_nxt.entry_length    = e_len;
            res_nxt.entry_cost      = e_cost;
          end
          state_nxt = pau_pkg::ST_DONE;
        end else begin
          rd_pend_nxt = 1'b1;
        end
      end

      pau_pkg::ST_DONE: begin
        if (!out_valid_r) begin
          res_nxt.entry_count     = 5'(count_r);
          res_nxt.min_length      = lmin_r;
          res_nxt.max_length_seen = lmax_r;
          res_nxt.lowest_cost     = cmin_r;
          res_nxt.max_cost        = cmax_r;
          out_valid_nxt           = 1'b1;
        end else if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = pau_pkg::ST_IDLE;
        end
      end

      default: state_nxt = pau_pkg::ST_IDLE;
    endcase
  end

  // never ready while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("ready while result pending");
  // count never exceeds the depth
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(ARCHIVE_DEPTH))
    else $error("archive count overflow");
  // accepted and full_drop exclusive
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.accepted && out_item.full_drop))
    else $error("accepted and full_drop both set");
  // hold a stalled result steady
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
